@@ hw/rtl/stcd_pkg.sv @@
package stcd_pkg;

	// Number of register stages from an input transfer to the output register.
	localparam int unsigned NUM_STAGES = 10;

	// Width of the day offset register and its value after reset (Unix time).
	localparam int unsigned OFFSET_W = 20;
	localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd719468;

	// Seconds per day is 2^7 * 675; the quotient by 675 uses a reciprocal.
	localparam logic [15:0] DAY_RECIP = 16'd49710;
	localparam logic [9:0] DAY_ODD_DIV = 10'd675;

	// Reciprocals for division by 365 (k = 16 and k = 18), 153 (k = 11), 15 (k = 15, k = 9).
	localparam logic [7:0] Y365_RECIP_16 = 8'd179;
	localparam logic [9:0] Y365_RECIP_18 = 10'd718;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [3:0] MP_RECIP = 4'd13;
	localparam logic [7:0] MP_DIV = 8'd153;
	localparam logic [11:0] MIN_RECIP = 12'd2184;
	localparam logic [5:0] HOUR_RECIP = 6'd34;
	localparam logic [3:0] DIV15 = 4'd15;

	// Day counts at the edges of each 4-year and 100-year block within an era.
	localparam logic [17:0] DAYS_4Y = 18'd1460;
	localparam logic [17:0] DAYS_100Y = 18'd36524;
	localparam logic [17:0] DAYS_ERA_LAST = 18'd146096;
	localparam logic [11:0] YEARS_PER_ERA = 12'd400;

	// Calendar date of one result.
	typedef struct packed {
		logic [11:0] year;
		logic [3:0] month;
		logic [4:0] day;
	} date_t;

	// Time of day of one result.
	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} tod_t;

	// First day of an era, counted from day 0 of the shifted scale.
	function automatic logic [20:0] era_base(input logic [2:0] era);
		logic [20:0] base;
		case (era)
			3'd0: base = 21'd0;
			3'd1: base = 21'd146097;
			3'd2: base = 21'd292194;
			3'd3: base = 21'd438291;
			3'd4: base = 21'd584388;
			3'd5: base = 21'd730485;
			3'd6: base = 21'd876582;
			default: base = 21'd1022679;
		endcase
		return base;
	endfunction

	// Day of the March-based year on which month index mp begins.
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] start;
		case (mp)
			4'd0: start = 9'd0;
			4'd1: start = 9'd31;
			4'd2: start = 9'd61;
			4'd3: start = 9'd92;
			4'd4: start = 9'd122;
			4'd5: start = 9'd153;
			4'd6: start = 9'd184;
			4'd7: start = 9'd214;
			4'd8: start = 9'd245;
			4'd9: start = 9'd275;
			4'd10: start = 9'd306;
			4'd11: start = 9'd337;
			default: start = 9'd0;
		endcase
		return start;
	endfunction

endpackage

@@ hw/rtl/stcd_day_split.sv @@
module stcd_day_split import stcd_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [31:0]         timestamp,
	input  logic [OFFSET_W-1:0] day_offset,
	output logic [20:0]         days_s2,
	output logic [16:0]         sod_s2
);

	logic [24:0] dx_s1;
	logic [6:0]  lo_s1;
	logic [40:0] dprod_s1;

	logic [15:0] q_est;
	logic [24:0] r_est;
	logic        r_over;
	logic [15:0] q_day;
	logic [24:0] r_day;

	// Stage 1: estimate seconds / 86400 as (seconds >> 7) / 675 by reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= timestamp[31:7];
			lo_s1    <= timestamp[6:0];
			dprod_s1 <= 41'(timestamp[31:7]) * 41'(DAY_RECIP);
		end
	end

	// The estimate is low by at most one; one compare and subtract fixes it.
	always_comb begin
		q_est  = dprod_s1[40:25];
		r_est  = dx_s1 - 25'(25'(q_est) * 25'(DAY_ODD_DIV));
		r_over = (r_est >= 25'(DAY_ODD_DIV));
		q_day  = r_over ? q_est + 16'd1 : q_est;
		r_day  = r_over ? r_est - 25'(DAY_ODD_DIV) : r_est;
	end

	// Stage 2: shift the day count onto the March-based scale.
	always_ff @(posedge clk) begin
		if (en) begin
			days_s2 <= 21'(q_day) + 21'(day_offset);
			sod_s2  <= {r_day[9:0], lo_s1};
		end
	end

endmodule

@@ hw/rtl/stcd_tod.sv @@
module stcd_tod import stcd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] sod_s2,
	output tod_t        tod_s10
);

	logic [14:0] tx_s3;
	logic [1:0]  tlo_s3;
	logic [26:0] tprod_s3;

	logic [11:0] tq_est;
	logic [14:0] tr_est;
	logic        tr_over;
	logic [11:0] tq;
	logic [14:0] tr;

	logic [10:0] tm_s4;
	logic [5:0]  sec_s4;

	logic [8:0]  hx_s5;
	logic [1:0]  hlo_s5;
	logic [14:0] hprod_s5;
	logic [5:0]  sec_s5;

	logic [5:0]  hq_est;
	logic [8:0]  hr_est;
	logic        hr_over;
	logic [5:0]  hq;
	logic [8:0]  hr;

	tod_t tod_s6;
	tod_t tod_s7;
	tod_t tod_s8;
	tod_t tod_s9;

	// Stage 3: minutes of the day as (sod >> 2) / 15 by reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s3    <= sod_s2[16:2];
			tlo_s3   <= sod_s2[1:0];
			tprod_s3 <= 27'(sod_s2[16:2]) * 27'(MIN_RECIP);
		end
	end

	// Correct the minute estimate; the remainder rebuilds the seconds.
	always_comb begin
		tq_est  = tprod_s3[26:15];
		tr_est  = tx_s3 - 15'(15'(tq_est) * 15'(DIV15));
		tr_over = (tr_est >= 15'(DIV15));
		tq      = tr_over ? tq_est + 12'd1 : tq_est;
		tr      = tr_over ? tr_est - 15'(DIV15) : tr_est;
	end

	// Stage 4: minute of day and second of minute.
	always_ff @(posedge clk) begin
		if (en) begin
			tm_s4  <= tq[10:0];
			sec_s4 <= {tr[3:0], tlo_s3};
		end
	end

	// Stage 5: hours as (minute of day >> 2) / 15 by reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s5    <= tm_s4[10:2];
			hlo_s5   <= tm_s4[1:0];
			hprod_s5 <= 15'(tm_s4[10:2]) * 15'(HOUR_RECIP);
			sec_s5   <= sec_s4;
		end
	end

	// Correct the hour estimate; the remainder rebuilds the minutes.
	always_comb begin
		hq_est  = hprod_s5[14:9];
		hr_est  = hx_s5 - 9'(9'(hq_est) * 9'(DIV15));
		hr_over = (hr_est >= 9'(DIV15));
		hq      = hr_over ? hq_est + 6'd1 : hq_est;
		hr      = hr_over ? hr_est - 9'(DIV15) : hr_est;
	end

	// Stage 6, then a delay line that lines the time up with the date path.
	always_ff @(posedge clk) begin
		if (en) begin
			tod_s6.hours   <= hq[4:0];
			tod_s6.minutes <= {hr[3:0], hlo_s5};
			tod_s6.seconds <= sec_s5;
			tod_s7         <= tod_s6;
			tod_s8         <= tod_s7;
			tod_s9         <= tod_s8;
			tod_s10        <= tod_s9;
		end
	end

endmodule

@@ hw/rtl/stcd_date.sv @@
module stcd_date import stcd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [20:0] days_s2,
	output date_t       date_s10
);

	logic [2:0]  era_c;
	logic [20:0] doe_full;

	logic [2:0]  era_s3;
	logic [17:0] doe_s3;

	logic [2:0]  c4;
	logic [2:0]  era_s4;
	logic [17:0] doe_s4;
	logic [15:0] xa_s4;
	logic [23:0] prod_a_s4;
	logic [2:0]  c100_s4;
	logic        cera_s4;

	logic [7:0]  qa_est;
	logic [15:0] ra_est;
	logic        ra_over;
	logic [7:0]  qa;

	logic [2:0]  era_s5;
	logic [17:0] doe_s5;
	logic [17:0] n_s5;

	logic [2:0]  era_s6;
	logic [17:0] doe_s6;
	logic [17:0] n_s6;
	logic [27:0] prod_b_s6;

	logic [9:0]  qb_est;
	logic [17:0] rb_est;
	logic        rb_over;
	logic [9:0]  qb;

	logic [2:0]  era_s7;
	logic [17:0] doe_s7;
	logic [8:0]  yoe_s7;

	logic [1:0]  cent;
	logic [17:0] yoe_base;

	logic [2:0]  era_s8;
	logic [8:0]  yoe_s8;
	logic [8:0]  doy_s8;

	logic [10:0] mt;
	logic [14:0] mprod;
	logic [3:0]  mq_est;
	logic [10:0] mr_est;
	logic [3:0]  mq;

	logic [2:0]  era_s9;
	logic [8:0]  yoe_s9;
	logic [8:0]  doy_s9;
	logic [3:0]  mp_s9;

	logic [3:0]  mm;
	logic [8:0]  dd_full;

	// Era index from seven parallel compares against the era boundaries.
	always_comb begin
		era_c = 3'd0;
		for (int k = 1; k < 8; k++) begin
			if (days_s2 >= era_base(3'(k))) begin
				era_c = era_c + 3'd1;
			end
		end
		doe_full = days_s2 - era_base(era_c);
	end

	// Stage 3: era and day of era.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s3 <= era_c;
			doe_s3 <= doe_full[17:0];
		end
	end

	// Count of complete 100-year blocks, including the final day of the era.
	always_comb begin
		c4 = 3'd0;
		for (int k = 1; k < 5; k++) begin
			if (doe_s3 >= 18'(k * 36524)) begin
				c4 = c4 + 3'd1;
			end
		end
	end

	// Stage 4: estimate doe / 1460 as (doe >> 2) / 365 by reciprocal.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s4    <= era_s3;
			doe_s4    <= doe_s3;
			xa_s4     <= doe_s3[17:2];
			prod_a_s4 <= 24'(doe_s3[17:2]) * 24'(Y365_RECIP_16);
			c100_s4   <= c4;
			cera_s4   <= (doe_s3 >= DAYS_ERA_LAST);
		end
	end

	// Correct the leap-block count.
	always_comb begin
		qa_est  = prod_a_s4[23:16];
		ra_est  = xa_s4 - 16'(16'(qa_est) * 16'(DAYS_PER_YEAR));
		ra_over = (ra_est >= 16'(DAYS_PER_YEAR));
		qa      = ra_over ? qa_est + 8'd1 : qa_est;
	end

	// Stage 5: day of era with the leap days taken out.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s5 <= era_s4;
			doe_s5 <= doe_s4;
			n_s5   <= doe_s4 - 18'(qa) + 18'(c100_s4) - 18'(cera_s4);
		end
	end

	// Stage 6: estimate the year of era by reciprocal of 365.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s6    <= era_s5;
			doe_s6    <= doe_s5;
			n_s6      <= n_s5;
			prod_b_s6 <= 28'(n_s5) * 28'(Y365_RECIP_18);
		end
	end

	// Correct the year of era.
	always_comb begin
		qb_est  = prod_b_s6[27:18];
		rb_est  = n_s6 - 18'(18'(qb_est) * 18'(DAYS_PER_YEAR));
		rb_over = (rb_est >= 18'(DAYS_PER_YEAR));
		qb      = rb_over ? qb_est + 10'd1 : qb_est;
	end

	// Stage 7: year of era.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s7 <= era_s6;
			doe_s7 <= doe_s6;
			yoe_s7 <= qb[8:0];
		end
	end

	// First day of the year within the era.
	always_comb begin
		cent = 2'd0;
		for (int k = 1; k < 4; k++) begin
			if (yoe_s7 >= 9'(k * 100)) begin
				cent = cent + 2'd1;
			end
		end
		yoe_base = 18'(18'(yoe_s7) * 18'(DAYS_PER_YEAR)) + 18'(yoe_s7[8:2]) - 18'(cent);
	end

	// Stage 8: day of the March-based year.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s8 <= era_s7;
			yoe_s8 <= yoe_s7;
			doy_s8 <= 9'(doe_s7 - yoe_base);
		end
	end

	// Month index (5 * doy + 2) / 153 by reciprocal and correction.
	always_comb begin
		mt     = 11'(11'(doy_s8) * 11'd5) + 11'd2;
		mprod  = 15'(mt) * 15'(MP_RECIP);
		mq_est = mprod[14:11];
		mr_est = mt - 11'(11'(mq_est) * 11'(MP_DIV));
		mq     = (mr_est >= 11'(MP_DIV)) ? mq_est + 4'd1 : mq_est;
	end

	// Stage 9: month index from March.
	always_ff @(posedge clk) begin
		if (en) begin
			era_s9 <= era_s8;
			yoe_s9 <= yoe_s8;
			doy_s9 <= doy_s8;
			mp_s9  <= mq;
		end
	end

	// Calendar month, day of month and the year bump for January and February.
	always_comb begin
		mm      = (mp_s9 < 4'd10) ? mp_s9 + 4'd3 : mp_s9 - 4'd9;
		dd_full = doy_s9 - month_start(mp_s9) + 9'd1;
	end

	// Stage 10: output date.
	always_ff @(posedge clk) begin
		if (en) begin
			date_s10.year  <= 12'(yoe_s9) + 12'(12'(era_s9) * YEARS_PER_ERA)
				+ 12'(mm <= 4'd2);
			date_s10.month <= mm;
			date_s10.day   <= dd_full[4:0];
		end
	end

endmodule

@@ hw/rtl/seconds_to_calendar_date.sv @@
// Converts a 32-bit count of seconds into a Gregorian date and a time of day.
// Input channel: timestamp with in_valid; the block drives in_stall.
// Output channel: year, month, day, hours, minutes, seconds with out_valid;
// the receiver drives out_stall. A transfer happens when valid is high and
// stall is low. The day offset register is written by cfg_wr_en/cfg_wr_data
// and adds that many days to the day count; the register may only be
// written while no conversion is in flight.
// out_valid rises when an input transfer reaches the output register. The
// pipeline takes one item every cycle unless the receiver stalls it; its
// ten stages are set by the chain of reciprocal multiplies and corrections
// for the day, era, year and month.
// When the receiver stalls with a result waiting, every stage holds and
// in_stall goes high in the same cycle; when the output stage is empty or
// taken, the pipeline advances and bubbles flow through.
// Reset clears all stage valid bits and loads the offset for Unix time
// (719468 days from 0000-03-01 to 1970-01-01).
module seconds_to_calendar_date import stcd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [OFFSET_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         timestamp,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [11:0]         year,
	output logic [3:0]          month,
	output logic [4:0]          day,
	output logic [4:0]          hours,
	output logic [5:0]          minutes,
	output logic [5:0]          seconds
);

	logic [OFFSET_W-1:0] offset_q;
	logic [NUM_STAGES:1] valid_s;
	logic                adv;
	logic [20:0]         days_s2;
	logic [16:0]         sod_s2;
	date_t               date_s10;
	tod_t                tod_s10;

	// The pipeline moves unless a finished result is held by the receiver.
	assign adv      = !(valid_s[NUM_STAGES] && out_stall);
	assign in_stall = !adv;

	// Day offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	// Valid bits travel with the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[NUM_STAGES-1:1], in_valid};
		end
	end

	stcd_day_split u_split (
		.clk        (clk),
		.en         (adv),
		.timestamp  (timestamp),
		.day_offset (offset_q),
		.days_s2    (days_s2),
		.sod_s2     (sod_s2)
	);

	stcd_date u_date (
		.clk      (clk),
		.en       (adv),
		.days_s2  (days_s2),
		.date_s10 (date_s10)
	);

	stcd_tod u_tod (
		.clk     (clk),
		.en      (adv),
		.sod_s2  (sod_s2),
		.tod_s10 (tod_s10)
	);

	// Output stage.
	assign out_valid = valid_s[NUM_STAGES];
	assign year      = date_s10.year;
	assign month     = date_s10.month;
	assign day       = date_s10.day;
	assign hours     = tod_s10.hours;
	assign minutes   = tod_s10.minutes;
	assign seconds   = tod_s10.seconds;

endmodule

@@ hw/rtl/stcd_checker.sv @@
module stcd_checker import stcd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_wr_en,
	input logic [OFFSET_W-1:0] cfg_wr_data,
	input logic                in_valid,
	input logic                in_stall,
	input logic [31:0]         timestamp,
	input logic                out_valid,
	input logic                out_stall,
	input logic [11:0]         year,
	input logic [3:0]          month,
	input logic [4:0]          day,
	input logic [4:0]          hours,
	input logic [5:0]          minutes,
	input logic [5:0]          seconds
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result does not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({year, month, day, hours, minutes, seconds}))
		else $error("result changed while stalled");

	// The input side only stalls while a finished result is blocked.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// Every offered result has its fields within the ranges of a date and time of day.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
			&& hours <= 5'd23 && minutes <= 6'd59 && seconds <= 6'd59)
		else $error("result field out of range");

endmodule

bind seconds_to_calendar_date stcd_checker u_stcd_checker (.*);
